>>> hdl/ist_pkg.sv
// Shared types and constants for the interval step timer.
// Used by ist_ctrl, ist_outq and interval_step_timer_core; no dependencies.
package ist_pkg;

  localparam int MAX_STEPS = 16;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int SEC_W     = 16;
  localparam int MS_W      = 10;
  localparam int DMS_W     = 12;
  localparam int CFG_W     = 5;

  localparam logic [CNT_W-1:0] MAX_STEPS_CNT = CNT_W'(MAX_STEPS);
  localparam logic [MS_W-1:0]  MS_PER_SEC    = 10'd1000;
  localparam logic [DMS_W-1:0] DONE_HOLD_MS  = 12'd3000;
  localparam logic [SEC_W-1:0] NO_MARK       = 16'hFFFF;
  localparam logic [3:0]       NO_SECOND     = 4'hF;

  localparam logic CFG_NUM_STEPS = 1'b0;
  localparam logic CFG_VOLUME    = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_SKIP   = 3'd4,
    CMD_RESET  = 3'd5,
    CMD_LOAD   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    CUE_NONE     = 3'd0,
    CUE_START    = 3'd1,
    CUE_THIRTY   = 3'd2,
    CUE_SECOND   = 3'd3,
    CUE_FINAL3   = 3'd4,
    CUE_STEP_END = 3'd5,
    CUE_DONE     = 3'd6
  } cue_e;

  localparam logic [1:0] PHC_READY = 2'd0;
  localparam logic [1:0] PHC_RUN   = 2'd1;
  localparam logic [1:0] PHC_PAUSE = 2'd2;
  localparam logic [1:0] PHC_DONE  = 2'd3;

  // One request's outcome: up to two cues plus the state after the request.
  typedef struct packed {
    cue_e             cue0;
    cue_e             cue1;
    logic             two;
    logic [1:0]       phase;
    logic [CNT_W-1:0] step;
    logic [SEC_W-1:0] secs;
  } rec_t;

endpackage

>>> hdl/interval_step_timer_core.sv
// Channel   Dir  Fields (lowest bit first)
// s_t*      in   cmd[2:0], step_index[6:3], step_duration[22:7], step_end_cue[23]
// m_t*      out  cue[2:0], phase[4:3], step_now[9:5], seconds_left[25:10]; last on tlast
// cfg_*     in   index 0 num_steps, index 1 volume_level; taken when cfg_we_i is high
// A request is decoded and the sequencer state updated in the cycle it is accepted.
// Its outcome is registered in a two-entry result queue before it is offered on m_t*.
// A request yields one beat, or two when a step-end cue precedes a start or done cue,
// so with m_tready_i high it takes one request per cycle, fewer for two-beat outcomes.
// After reset the block is ready at once; a stalled output fills the queue and drops s_tready_o.
module interval_step_timer_core import ist_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [23:0]      s_tdata_i,   // cmd, step_index, step_duration, step_end_cue
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [31:0]      m_tdata_o,   // cue, phase, step_now, seconds_left, zero fill
  output logic             m_tlast_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic             fire;
  rec_t             rec;
  logic [2:0]       cue;
  logic [1:0]       phase;
  logic [CNT_W-1:0] step;
  logic [SEC_W-1:0] secs;

  assign fire = s_tvalid_i && s_tready_o;

  ist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (s_tdata_i[2:0]),
    .idx_i      (s_tdata_i[6:3]),
    .dur_i      (s_tdata_i[22:7]),
    .flag_i     (s_tdata_i[23]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rec_o      (rec)
  );

  ist_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .rec_i  (rec),
    .ready_o(s_tready_o),
    .valid_o(m_tvalid_o),
    .take_i (m_tready_i),
    .cue_o  (cue),
    .phase_o(phase),
    .step_o (step),
    .secs_o (secs),
    .last_o (m_tlast_o)
  );

  assign m_tdata_o = {6'b0, secs, step, phase, cue};

endmodule

>>> hdl/ist_ctrl.sv
// Sequencer state, step table and cue generation for one request per cycle.
// Depends on ist_pkg.
module ist_ctrl import ist_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [2:0]       cmd_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [SEC_W-1:0] dur_i,
  input  logic             flag_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output rec_t             rec_o
);

  typedef enum logic [3:0] {
    PH_READY = 4'b0001,
    PH_RUN   = 4'b0010,
    PH_PAUSE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] sc_q, sc_d;
  logic [SEC_W-1:0] sec_q, sec_d;
  logic [MS_W-1:0]  ms_q, ms_d;
  logic [DMS_W-1:0] dms_q, dms_d;
  logic [SEC_W-1:0] l30_q, l30_d;
  logic [3:0]       lsec_q, lsec_d;
  logic [CNT_W-1:0] num_q;
  logic [1:0]       vol_q;

  logic [SEC_W-1:0] len_q [MAX_STEPS];
  logic             flg_q [MAX_STEPS];

  cmd_e             cmd;
  logic [CNT_W-1:0] active;
  logic [MS_W-1:0]  ms_inc;
  logic             ms_wrap;
  logic [DMS_W-1:0] dms_inc;
  logic [SEC_W-1:0] rem;
  logic [32:0]      prod;
  logic [11:0]      quo;
  logic [16:0]      m30;
  logic             is30;
  logic             do_ready, finish, begin_req, end_cue, mark_v;
  cue_e             mark_cue, beg_cue;
  logic [CNT_W-1:0] nsc;
  cue_e             c_a, c_b;
  logic             two;
  logic [1:0]       ph_code;

  assign cmd     = cmd_e'(cmd_i);
  assign active  = (num_q > MAX_STEPS_CNT) ? MAX_STEPS_CNT : num_q;
  assign ms_inc  = ms_q + 10'd1;
  assign ms_wrap = (ms_inc >= MS_PER_SEC);
  assign dms_inc = dms_q + 12'd1;
  assign rem     = (ms_wrap && sec_q != '0) ? sec_q - 16'd1 : sec_q;

  // Divisibility by thirty through a reciprocal multiply; exact for 16-bit values.
  assign prod = 33'(rem) * 33'd34953;
  assign quo  = prod[31:20];
  assign m30  = {quo, 5'b0} - {4'b0, quo, 1'b0};
  assign is30 = (m30[SEC_W-1:0] == rem);

  always_comb begin
    phase_d   = phase_q;
    sc_d      = sc_q;
    sec_d     = sec_q;
    ms_d      = ms_q;
    dms_d     = dms_q;
    l30_d     = l30_q;
    lsec_d    = lsec_q;
    do_ready  = 1'b0;
    finish    = 1'b0;
    begin_req = 1'b0;
    end_cue   = 1'b0;
    mark_v    = 1'b0;
    mark_cue  = CUE_NONE;
    beg_cue   = CUE_NONE;
    nsc       = sc_q;
    if (fire_i) begin
      unique case (cmd)
        CMD_TICK: begin
          if (phase_q == PH_DONE) begin
            if (dms_inc >= DONE_HOLD_MS) begin
              do_ready = 1'b1;
            end else begin
              dms_d = dms_inc;
            end
          end else if (phase_q == PH_RUN) begin
            ms_d  = ms_wrap ? '0 : ms_inc;
            sec_d = rem;
            if (rem == '0) begin
              finish = 1'b1;
            end else if (is30 && rem > 16'd10 && l30_q != rem) begin
              mark_v   = 1'b1;
              mark_cue = CUE_THIRTY;
              l30_d    = rem;
            end else if (rem <= 16'd10 && rem > 16'd3 && lsec_q != rem[3:0]) begin
              mark_v   = 1'b1;
              mark_cue = CUE_SECOND;
              lsec_d   = rem[3:0];
            end else if (rem <= 16'd3 && lsec_q != rem[3:0]) begin
              mark_v   = 1'b1;
              mark_cue = CUE_FINAL3;
              lsec_d   = rem[3:0];
            end
          end
        end
        CMD_START: begin
          if (phase_q == PH_READY) begin
            begin_req = 1'b1;
          end
        end
        CMD_PAUSE: begin
          if (phase_q == PH_RUN) begin
            phase_d = PH_PAUSE;
          end
        end
        CMD_RESUME: begin
          if (phase_q == PH_PAUSE) begin
            phase_d = PH_RUN;
            ms_d    = '0;
          end
        end
        CMD_SKIP: begin
          if (phase_q == PH_RUN || phase_q == PH_PAUSE) begin
            finish = 1'b1;
          end
        end
        CMD_RESET: begin
          do_ready = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_ready) begin
      sc_d    = '0;
      sec_d   = len_q[0];
      phase_d = PH_READY;
      ms_d    = '0;
      dms_d   = '0;
      l30_d   = NO_MARK;
      lsec_d  = NO_SECOND;
    end

    if (finish) begin
      end_cue   = (sc_q < MAX_STEPS_CNT) && flg_q[sc_q[IDX_W-1:0]];
      begin_req = 1'b1;
      nsc       = (sc_q < MAX_STEPS_CNT) ? sc_q + 5'd1 : sc_q;
    end

    if (begin_req) begin
      sc_d = nsc;
      if (nsc >= active) begin
        phase_d = PH_DONE;
        dms_d   = '0;
        beg_cue = CUE_DONE;
      end else begin
        sec_d   = len_q[nsc[IDX_W-1:0]];
        ms_d    = '0;
        phase_d = PH_RUN;
        l30_d   = NO_MARK;
        lsec_d  = NO_SECOND;
        beg_cue = CUE_START;
      end
    end
  end

  always_comb begin
    c_a = CUE_NONE;
    c_b = CUE_NONE;
    two = 1'b0;
    if (mark_v) begin
      c_a = mark_cue;
    end else if (begin_req) begin
      if (end_cue) begin
        c_a = CUE_STEP_END;
        c_b = beg_cue;
        two = 1'b1;
      end else begin
        c_a = beg_cue;
      end
    end
    if (vol_q == 2'd0) begin
      c_a = CUE_NONE;
      c_b = CUE_NONE;
      two = 1'b0;
    end
  end

  always_comb begin
    unique case (phase_d)
      PH_READY: ph_code = PHC_READY;
      PH_RUN:   ph_code = PHC_RUN;
      PH_PAUSE: ph_code = PHC_PAUSE;
      PH_DONE:  ph_code = PHC_DONE;
      default:  ph_code = PHC_READY;
    endcase
  end

  assign rec_o = '{cue0: c_a, cue1: c_b, two: two, phase: ph_code, step: sc_d, secs: sec_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_READY;
      sc_q    <= '0;
      sec_q   <= '0;
      ms_q    <= '0;
      dms_q   <= '0;
      l30_q   <= NO_MARK;
      lsec_q  <= NO_SECOND;
    end else begin
      phase_q <= phase_d;
      sc_q    <= sc_d;
      sec_q   <= sec_d;
      ms_q    <= ms_d;
      dms_q   <= dms_d;
      l30_q   <= l30_d;
      lsec_q  <= lsec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 5'd1;
      vol_q <= 2'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_STEPS) begin
        num_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_VOLUME) begin
        vol_q <= cfg_wdata_i[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && cmd == CMD_LOAD) begin
      len_q[idx_i] <= dur_i;
      flg_q[idx_i] <= flag_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q < MS_PER_SEC) else $error("ms count out of range");
  a_dms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dms_q < DONE_HOLD_MS) else $error("done hold count out of range");
  a_lsec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lsec_q <= 4'd10 || lsec_q == NO_SECOND)) else $error("bad last second");
  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && cmd == CMD_RESET) |=> (phase_q == PH_READY && sc_q == '0))
    else $error("reset request did not return to ready");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= MAX_STEPS_CNT) else $error("step counter out of range");
`endif

endmodule

>>> hdl/ist_outq.sv
// Two-entry result queue that splits each request's outcome into one or two
// stream beats. Depends on ist_pkg.
module ist_outq import ist_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rec_t             rec_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             take_i,
  output logic [2:0]       cue_o,
  output logic [1:0]       phase_o,
  output logic [CNT_W-1:0] step_o,
  output logic [SEC_W-1:0] secs_o,
  output logic             last_o
);

  rec_t       buf_q [2];
  logic       wr_q, rd_q, sub_q;
  logic [1:0] cnt_q, cnt_d;
  rec_t       head;
  logic       pop;

  assign head    = buf_q[rd_q];
  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign last_o  = !head.two || sub_q;
  assign cue_o   = sub_q ? head.cue1 : head.cue0;
  assign phase_o = head.phase;
  assign step_o  = head.step;
  assign secs_o  = head.secs;
  assign pop     = valid_o && take_i && last_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sub_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q  <= !rd_q;
        sub_q <= 1'b0;
      end else if (valid_o && take_i) begin
        sub_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= rec_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2 || pop)) else $error("result queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result queue count out of range");
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (valid_o && head.two)) else $error("second beat without a second cue");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("queue pointers disagree with count");
`endif

endmodule
